/* sv/sapq_pkg.sv */
// Shared types and codes for the slot-array minimum priority queue.
package sapq_pkg;

  // Operation selector carried on in_tuser
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_POLL = 1'b1;

  // Result status codes carried on out_tuser
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // Width of the occupancy field in a result
  localparam int unsigned OCC_BITS = 5;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_ADD_SCAN,
    S_RESCAN,
    S_RESCAN_TAIL,
    S_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic latch;        // capture the accepted item, rewind slot index
    logic reply_full;   // result: add on full queue
    logic reply_empty;  // result: poll on empty queue
    logic add_step;     // test one slot, write entry if free
    logic poll_take;    // hand out cached minimum and free its slot
    logic scan_read;    // read one slot for the minimum rescan
    logic push;         // move pending result into the output register
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic op_poll;
    logic full;
    logic poll_fail;
    logic slot_free;
    logic scan_last;
    logic out_busy;
  } dp_stat_t;

endpackage

/* sv/sapq_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module sapq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/sapq_datapath.sv */
// Datapath: slot storage, used bits, cached minimum, slot index and result registers.
module sapq_datapath #(
  parameter int unsigned DEPTH        = 16,
  parameter int unsigned KEY_BITS     = 16,
  parameter int unsigned PAYLOAD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sapq_pkg::dp_cmd_t            cmd,
  output sapq_pkg::dp_stat_t           stat,
  input  logic                         in_op,
  input  logic [KEY_BITS-1:0]          in_key,
  input  logic [PAYLOAD_BITS-1:0]      in_payload,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [KEY_BITS-1:0]          out_key,
  output logic [PAYLOAD_BITS-1:0]      out_payload,
  output logic [1:0]                   out_status,
  output logic [sapq_pkg::OCC_BITS-1:0] out_occupancy
);

  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned ENT_W  = KEY_BITS + PAYLOAD_BITS;
  localparam int unsigned OCC_W  = sapq_pkg::OCC_BITS;

  // Control state
  logic [DEPTH-1:0] used_r, used_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] min_idx_r, min_idx_nxt;
  logic             min_known_r, min_known_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Payload registers
  logic [KEY_BITS-1:0]     min_key_r, min_key_nxt;
  logic [PAYLOAD_BITS-1:0] min_pay_r, min_pay_nxt;
  logic                    op_r, op_nxt;
  logic [KEY_BITS-1:0]     op_key_r, op_key_nxt;
  logic [PAYLOAD_BITS-1:0] op_pay_r, op_pay_nxt;
  logic [IDX_W-1:0]        rd_idx_r, rd_idx_nxt;
  logic [KEY_BITS-1:0]     res_key_r, res_key_nxt;
  logic [PAYLOAD_BITS-1:0] res_pay_r, res_pay_nxt;
  logic [1:0]              res_status_r, res_status_nxt;
  logic [KEY_BITS-1:0]     out_key_r, out_key_nxt;
  logic [PAYLOAD_BITS-1:0] out_pay_r, out_pay_nxt;
  logic [1:0]              out_status_r, out_status_nxt;
  logic [OCC_W-1:0]        out_occ_r, out_occ_nxt;

  // Slot RAM signals
  logic             ram_we;
  logic [ENT_W-1:0] ram_wdata;
  logic [ENT_W-1:0] ram_rdata;
  logic [KEY_BITS-1:0]     rd_key;
  logic [PAYLOAD_BITS-1:0] rd_pay;
  logic [CNT_W+OCC_W-1:0]  occ_wide;

  sapq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (ram_wdata),
    .re    (cmd.scan_read),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign ram_wdata = {op_pay_r, op_key_r};
  assign rd_key    = ram_rdata[KEY_BITS-1:0];
  assign rd_pay    = ram_rdata[KEY_BITS +: PAYLOAD_BITS];
  assign ram_we    = cmd.add_step && !used_r[idx_r];
  assign occ_wide  = {{OCC_W{1'b0}}, count_r};

  // Status towards the controller
  always_comb begin
    stat.op_poll   = (op_r == sapq_pkg::OP_POLL);
    stat.full      = (count_r == CNT_W'(DEPTH));
    stat.poll_fail = (count_r == '0) || !min_known_r || !used_r[min_idx_r];
    stat.slot_free = !used_r[idx_r];
    stat.scan_last = (idx_r == IDX_W'(DEPTH - 1));
    stat.out_busy  = out_valid_r && !out_ready;
  end

  // Next-state logic of all registers
  always_comb begin
    used_nxt       = used_r;
    count_nxt      = count_r;
    min_idx_nxt    = min_idx_r;
    min_known_nxt  = min_known_r;
    min_key_nxt    = min_key_r;
    min_pay_nxt    = min_pay_r;
    idx_nxt        = idx_r;
    rd_pend_nxt    = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    op_nxt         = op_r;
    op_key_nxt     = op_key_r;
    op_pay_nxt     = op_pay_r;
    res_key_nxt    = res_key_r;
    res_pay_nxt    = res_pay_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_key_nxt    = out_key_r;
    out_pay_nxt    = out_pay_r;
    out_status_nxt = out_status_r;
    out_occ_nxt    = out_occ_r;

    // output register drains on a transfer
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cmd.latch) begin
      op_nxt     = in_op;
      op_key_nxt = in_key;
      op_pay_nxt = in_payload;
      idx_nxt    = '0;
    end

    if (cmd.reply_full || cmd.reply_empty) begin
      res_key_nxt    = '0;
      res_pay_nxt    = '0;
      res_status_nxt = cmd.reply_full ? sapq_pkg::STATUS_FULL : sapq_pkg::STATUS_EMPTY;
    end

    // add: first free slot takes the entry, otherwise move on
    if (cmd.add_step) begin
      if (!used_r[idx_r]) begin
        used_nxt[idx_r] = 1'b1;
        count_nxt       = count_r + 1'b1;
        res_key_nxt     = '0;
        res_pay_nxt     = '0;
        res_status_nxt  = sapq_pkg::STATUS_OK;
        if (!min_known_r || (op_key_r < min_key_r)) begin
          min_known_nxt = 1'b1;
          min_idx_nxt   = idx_r;
          min_key_nxt   = op_key_r;
          min_pay_nxt   = op_pay_r;
        end
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end

    // poll: hand out cached minimum, free it, start the rescan afresh
    if (cmd.poll_take) begin
      res_key_nxt        = min_key_r;
      res_pay_nxt        = min_pay_r;
      res_status_nxt     = sapq_pkg::STATUS_OK;
      used_nxt[min_idx_r] = 1'b0;
      count_nxt          = count_r - 1'b1;
      min_known_nxt      = 1'b0;
      min_idx_nxt        = '0;
      idx_nxt            = '0;
    end

    if (cmd.scan_read) begin
      rd_pend_nxt = 1'b1;
      rd_idx_nxt  = idx_r;
      idx_nxt     = idx_r + 1'b1;
    end

    // rescan compare on last cycle's read data; strict less keeps lowest index
    if (rd_pend_r && used_r[rd_idx_r]) begin
      if (!min_known_r || (rd_key < min_key_r)) begin
        min_known_nxt = 1'b1;
        min_idx_nxt   = rd_idx_r;
        min_key_nxt   = rd_key;
        min_pay_nxt   = rd_pay;
      end
    end

    if (cmd.push) begin
      out_valid_nxt  = 1'b1;
      out_key_nxt    = res_key_r;
      out_pay_nxt    = res_pay_r;
      out_status_nxt = res_status_r;
      out_occ_nxt    = occ_wide[OCC_W-1:0];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      count_r     <= '0;
      min_idx_r   <= '0;
      min_known_r <= 1'b0;
      idx_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      count_r     <= count_nxt;
      min_idx_r   <= min_idx_nxt;
      min_known_r <= min_known_nxt;
      idx_r       <= idx_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    min_key_r    <= min_key_nxt;
    min_pay_r    <= min_pay_nxt;
    op_r         <= op_nxt;
    op_key_r     <= op_key_nxt;
    op_pay_r     <= op_pay_nxt;
    rd_idx_r     <= rd_idx_nxt;
    res_key_r    <= res_key_nxt;
    res_pay_r    <= res_pay_nxt;
    res_status_r <= res_status_nxt;
    out_key_r    <= out_key_nxt;
    out_pay_r    <= out_pay_nxt;
    out_status_r <= out_status_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_key       = out_key_r;
  assign out_payload   = out_pay_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occ_r;

  // Entry count tracks the used bits
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(used_r) == int'(count_r))
    else $error("entry count disagrees with used bits");

  // Count never passes the slot total
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= DEPTH)
    else $error("entry count above depth");

  // A known minimum always points at an occupied slot
  a_min_used: assert property (@(posedge clk) disable iff (!rst_n)
    min_known_r |-> used_r[min_idx_r])
    else $error("cached minimum on a free slot");

  // A result is only pushed into a free or draining output register
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (!out_valid_r || out_ready))
    else $error("result pushed over an untaken result");

endmodule

/* sv/sapq_ctrl.sv */
// Controller: sequencer for add, poll and the minimum rescan.
module sapq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sapq_pkg::dp_stat_t stat,
  output sapq_pkg::dp_cmd_t  cmd
);

  sapq_pkg::state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sapq_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = sapq_pkg::S_DISPATCH;
        end
      end
      sapq_pkg::S_DISPATCH: begin
        if (stat.op_poll) begin
          state_nxt = stat.poll_fail ? sapq_pkg::S_DONE : sapq_pkg::S_RESCAN;
        end else begin
          state_nxt = stat.full ? sapq_pkg::S_DONE : sapq_pkg::S_ADD_SCAN;
        end
      end
      sapq_pkg::S_ADD_SCAN: begin
        if (stat.slot_free) begin
          state_nxt = sapq_pkg::S_DONE;
        end
      end
      sapq_pkg::S_RESCAN: begin
        if (stat.scan_last) begin
          state_nxt = sapq_pkg::S_RESCAN_TAIL;
        end
      end
      sapq_pkg::S_RESCAN_TAIL: begin
        state_nxt = sapq_pkg::S_DONE;
      end
      sapq_pkg::S_DONE: begin
        if (!stat.out_busy) begin
          state_nxt = sapq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sapq_pkg::S_IDLE;
      end
    endcase
  end

  // Command outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      sapq_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      sapq_pkg::S_DISPATCH: begin
        if (stat.op_poll) begin
          cmd.reply_empty = stat.poll_fail;
          cmd.poll_take   = !stat.poll_fail;
        end else begin
          cmd.reply_full = stat.full;
        end
      end
      sapq_pkg::S_ADD_SCAN: begin
        cmd.add_step = 1'b1;
      end
      sapq_pkg::S_RESCAN: begin
        cmd.scan_read = 1'b1;
      end
      sapq_pkg::S_DONE: begin
        cmd.push = !stat.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sapq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* sv/slot_array_min_priority_queue_core.sv */
// Top level of the slot-array minimum priority queue with stream ports.
// Add: the free-slot search tests one slot a cycle from slot 0 until it finds a free one.
// Poll: the rescan reads one slot a cycle over every slot; a failed add or poll skips both.
// One item in work at a time; the next input is taken once the result enters the output register.
// Reset (synchronous, rst_n low) clears used bits, count and cached minimum at once.
module slot_array_min_priority_queue_core #(
  parameter int unsigned DEPTH        = 16,
  parameter int unsigned KEY_BITS     = 16,
  parameter int unsigned PAYLOAD_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // in_tdata fields from bit 0: key, payload, zero fill
  input  logic [((KEY_BITS + PAYLOAD_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  // in_tuser fields from bit 0: op
  input  logic in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // out_tdata fields from bit 0: key, payload, occupancy, zero fill
  output logic [((KEY_BITS + PAYLOAD_BITS + sapq_pkg::OCC_BITS + 7) / 8) * 8 - 1:0] out_tdata,
  // out_tuser fields from bit 0: status
  output logic [1:0] out_tuser
);

  localparam int unsigned OUT_W  = KEY_BITS + PAYLOAD_BITS + sapq_pkg::OCC_BITS;
  localparam int unsigned OUT_TW = ((OUT_W + 7) / 8) * 8;

  sapq_pkg::dp_cmd_t  cmd;
  sapq_pkg::dp_stat_t stat;

  logic [KEY_BITS-1:0]           res_key;
  logic [PAYLOAD_BITS-1:0]       res_pay;
  logic [sapq_pkg::OCC_BITS-1:0] res_occ;

  sapq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sapq_datapath #(
    .DEPTH        (DEPTH),
    .KEY_BITS     (KEY_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_op         (in_tuser),
    .in_key        (in_tdata[KEY_BITS-1:0]),
    .in_payload    (in_tdata[KEY_BITS +: PAYLOAD_BITS]),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_key       (res_key),
    .out_payload   (res_pay),
    .out_status    (out_tuser),
    .out_occupancy (res_occ)
  );

  // Pack result fields, zero filled to whole bytes
  assign out_tdata = OUT_TW'({res_occ, res_pay, res_key});

endmodule

/* bench/slot_array_min_priority_queue_core_test.sv */
// Self-checking testbench for the slot-array minimum priority queue core.
module slot_array_min_priority_queue_core_test;

  localparam int unsigned SLOTS      = 16;
  localparam int unsigned NUM_RANDOM = 1100;
  localparam int unsigned NUM_ROWS   = 26;
  localparam int unsigned SETTLE     = SLOTS + 8;

  // One result as seen on out_tdata and out_tuser
  typedef struct packed {
    logic [15:0] key;
    logic [15:0] payload;
    logic [1:0]  status;
    logic [4:0]  occupancy;
  } qresult_t;

  // One row of directed stimulus; want is used only where typed is set
  typedef struct packed {
    logic        op;
    logic [15:0] key;
    logic [15:0] payload;
    logic        typed;
    qresult_t    want;
  } directed_row_t;

  localparam qresult_t NO_WANT = '0;
  localparam logic [15:0] EDGE_KEYS [4] = '{16'h0000, 16'h0001, 16'hFFFE, 16'hFFFF};

  // Directed stimulus: empty poll, equal keys, extremes, fill to full, add on full
  localparam directed_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{sapq_pkg::OP_POLL, 16'h0000, 16'h0000, 1'b1,
      '{16'h0000, 16'h0000, sapq_pkg::STATUS_EMPTY, 5'd0}},
    '{sapq_pkg::OP_ADD,  16'hFFFF, 16'h0000, 1'b1,
      '{16'h0000, 16'h0000, sapq_pkg::STATUS_OK,    5'd1}},
    '{sapq_pkg::OP_ADD,  16'h0000, 16'hFFFF, 1'b1,
      '{16'h0000, 16'h0000, sapq_pkg::STATUS_OK,    5'd2}},
    '{sapq_pkg::OP_ADD,  16'h0000, 16'h1234, 1'b0, NO_WANT},
    '{sapq_pkg::OP_POLL, 16'hFFFF, 16'hFFFF, 1'b0, NO_WANT},
    '{sapq_pkg::OP_POLL, 16'h0000, 16'h0000, 1'b0, NO_WANT},
    '{sapq_pkg::OP_POLL, 16'h0000, 16'h0000, 1'b0, NO_WANT},
    '{sapq_pkg::OP_POLL, 16'hFFFF, 16'hFFFF, 1'b1,
      '{16'h0000, 16'h0000, sapq_pkg::STATUS_EMPTY, 5'd0}},
    '{sapq_pkg::OP_ADD,  16'h8000, 16'h0001, 1'b0, NO_WANT},
    '{sapq_pkg::OP_ADD,  16'h7FFF, 16'h8000, 1'b0, NO_WANT},
    '{sapq_pkg::OP_ADD,  16'h0001, 16'hAAAA, 1'b0, NO_WANT},
    '{sapq_pkg::OP_ADD,  16'hFFFE, 16'h5555, 1'b0, NO_WANT},
    '{sapq_pkg::OP_ADD,  16'hAAAA, 16'h00FF, 1'b0, NO_WANT},
    '{sapq_pkg::OP_ADD,  16'h5555, 16'hFF00, 1'b0, NO_WANT},
    '{sapq_pkg::OP_ADD,  16'h0001, 16'h0F0F, 1'b0, NO_WANT},
    '{sapq_pkg::OP_ADD,  16'h8000, 16'hF0F0, 1'b0, NO_WANT},
    '{sapq_pkg::OP_ADD,  16'h0100, 16'h0000, 1'b0, NO_WANT},
    '{sapq_pkg::OP_ADD,  16'h00FF, 16'hFFFF, 1'b0, NO_WANT},
    '{sapq_pkg::OP_ADD,  16'hFFFF, 16'h1111, 1'b0, NO_WANT},
    '{sapq_pkg::OP_ADD,  16'h0000, 16'h2222, 1'b0, NO_WANT},
    '{sapq_pkg::OP_ADD,  16'h1234, 16'h3333, 1'b0, NO_WANT},
    '{sapq_pkg::OP_ADD,  16'h4321, 16'h4444, 1'b0, NO_WANT},
    '{sapq_pkg::OP_ADD,  16'hFFFF, 16'h5555, 1'b0, NO_WANT},
    '{sapq_pkg::OP_ADD,  16'h0000, 16'h6666, 1'b0, NO_WANT},
    '{sapq_pkg::OP_ADD,  16'hFFFF, 16'hFFFF, 1'b1,
      '{16'h0000, 16'h0000, sapq_pkg::STATUS_FULL,  5'd16}},
    '{sapq_pkg::OP_POLL, 16'h0000, 16'h0000, 1'b0, NO_WANT}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // in_tdata fields from bit 0: key, payload
  logic [31:0] in_tdata = '0;
  // in_tuser fields from bit 0: op
  logic        in_tuser = sapq_pkg::OP_ADD;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // out_tdata fields from bit 0: key, payload, occupancy, zero fill
  logic [39:0] out_tdata;
  // out_tuser fields from bit 0: status
  logic [1:0]  out_tuser;

  // Mirror of the queue contents, updated on every accepted transfer
  logic        mirror_used [SLOTS];
  logic [15:0] mirror_key [SLOTS];
  logic [15:0] mirror_payload [SLOTS];
  logic [3:0]  mirror_min_idx;
  logic        mirror_min_known;
  int unsigned mirror_count;

  qresult_t    pending_results [$];
  qresult_t    oldest;
  bit          mismatch_seen = 1'b0;
  logic [10:0] stall_tick = '0;
  int unsigned burst_left = 0;

  slot_array_min_priority_queue_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Result side back-pressure: free running, light, heavy and pulsed phases
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1'b1;
    case (stall_tick[10:9])
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= ($urandom_range(0, 3) != 0);
      2'd2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= (stall_tick[2:0] == 3'd0);
    endcase
  end

  task automatic report_field(input string what, input logic [15:0] want_v,
                              input logic [15:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want_v, got_v);
      mismatch_seen = 1'b1;
    end
  endtask

  // Result checker: each transfer against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got key %0h payload %0h status %0d occ %0d",
                 $time, out_tdata[15:0], out_tdata[31:16], out_tuser, out_tdata[36:32]);
        mismatch_seen = 1'b1;
      end else begin
        oldest = pending_results.pop_front();
        report_field("key", oldest.key, out_tdata[15:0]);
        report_field("payload", oldest.payload, out_tdata[31:16]);
        report_field("status", {14'd0, oldest.status}, {14'd0, out_tuser});
        report_field("occupancy", {11'd0, oldest.occupancy}, {11'd0, out_tdata[36:32]});
      end
    end
  end

  // Apply one item to the mirror and return the result it should give
  function automatic qresult_t mirror_step(input logic op, input logic [15:0] k,
                                           input logic [15:0] p);
    qresult_t r;
    int       i;
    int       slot;
    r = '0;
    r.status = sapq_pkg::STATUS_OK;
    if (op == sapq_pkg::OP_ADD) begin
      if (mirror_count >= SLOTS) begin
        r.status = sapq_pkg::STATUS_FULL;
      end else begin
        slot = 0;
        while (mirror_used[4'(slot)]) slot++;
        mirror_used[4'(slot)]    = 1'b1;
        mirror_key[4'(slot)]     = k;
        mirror_payload[4'(slot)] = p;
        // an equal key leaves the cached minimum alone
        if (!mirror_min_known || k < mirror_key[mirror_min_idx]) begin
          mirror_min_idx   = slot[3:0];
          mirror_min_known = 1'b1;
        end
        mirror_count++;
      end
    end else if (mirror_count == 0 || !mirror_min_known) begin
      r.status = sapq_pkg::STATUS_EMPTY;
    end else begin
      r.key     = mirror_key[mirror_min_idx];
      r.payload = mirror_payload[mirror_min_idx];
      mirror_used[mirror_min_idx] = 1'b0;
      mirror_count--;
      // rescan from slot 0; lowest index wins among equal keys
      mirror_min_known = 1'b0;
      mirror_min_idx   = '0;
      for (i = 0; i < SLOTS; i++) begin
        if (mirror_used[4'(i)] &&
            (!mirror_min_known || mirror_key[4'(i)] < mirror_key[mirror_min_idx])) begin
          mirror_min_idx   = i[3:0];
          mirror_min_known = 1'b1;
        end
      end
    end
    r.occupancy = mirror_count[4:0];
    return r;
  endfunction

  // Send one item in bursts with random gaps, then log what it should return
  task automatic feed_item(input logic op, input logic [15:0] k, input logic [15:0] p,
                           input logic typed, input qresult_t want);
    int unsigned gap;
    qresult_t    predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {p, k};
    do @(posedge clk); while (!in_tready);
    predicted = mirror_step(op, k, p);
    pending_results.push_back(typed ? want : predicted);
  endtask

  initial begin
    int unsigned n;
    int unsigned add_pct;
    logic        op;
    logic [15:0] k;
    for (n = 0; n < SLOTS; n++) begin
      mirror_used[4'(n)]    = 1'b0;
      mirror_key[4'(n)]     = '0;
      mirror_payload[4'(n)] = '0;
    end
    mirror_min_idx   = '0;
    mirror_min_known = 1'b0;
    mirror_count     = 0;
    add_pct          = 50;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    for (n = 0; n < NUM_ROWS; n++) begin
      feed_item(DIRECTED_ROWS[5'(n)].op, DIRECTED_ROWS[5'(n)].key,
                DIRECTED_ROWS[5'(n)].payload, DIRECTED_ROWS[5'(n)].typed,
                DIRECTED_ROWS[5'(n)].want);
    end

    // Random traffic; the add share drifts so the queue swings between full and empty
    for (n = 0; n < NUM_RANDOM; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: add_pct = 15;
          1: add_pct = 50;
          default: add_pct = 85;
        endcase
      end
      // hold off until everything outstanding has drained
      if (n % 250 == 125) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      op = ($urandom_range(0, 99) < add_pct) ? sapq_pkg::OP_ADD : sapq_pkg::OP_POLL;
      case ($urandom_range(0, 3))
        0: k = 16'($urandom_range(0, 65535));
        1: k = 16'($urandom_range(0, 7));
        2: k = EDGE_KEYS[2'($urandom_range(0, 3))];
        default: k = 16'h8000 + 16'($urandom_range(0, 15)) - 16'd8;
      endcase
      feed_item(op, k, 16'($urandom_range(0, 65535)), 1'b0, NO_WANT);
    end

    // Drain and settle
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (!mismatch_seen) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1000000;
    $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
